// ===== sv/lzo_pkg.sv =====
// Package: shared payload types and status codes for the LZO1X stream decompressor.
package lzo_pkg;

  // Status codes reported with the final result
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_AFTER_END  = 3'd1;
  localparam logic [2:0] ST_NO_END     = 3'd2;
  localparam logic [2:0] ST_OVERRUN    = 3'd3;
  localparam logic [2:0] ST_LOOKBEHIND = 3'd4;
  localparam logic [2:0] ST_OVERFLOW   = 3'd5;
  localparam logic [2:0] ST_TURN       = 3'd6;

  // Item commands
  localparam logic CMD_FEED    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Decoder phases
  localparam logic [3:0] PH_FIRST    = 4'd0;
  localparam logic [3:0] PH_INSTR_A  = 4'd1;
  localparam logic [3:0] PH_INSTR_B  = 4'd2;
  localparam logic [3:0] PH_INSTR_C  = 4'd3;
  localparam logic [3:0] PH_LITEXT   = 4'd4;
  localparam logic [3:0] PH_LITS     = 4'd5;
  localparam logic [3:0] PH_TRAIL    = 4'd6;
  localparam logic [3:0] PH_M1_SHORT = 4'd7;
  localparam logic [3:0] PH_M1_LONG  = 4'd8;
  localparam logic [3:0] PH_M2B      = 4'd9;
  localparam logic [3:0] PH_MEXT     = 4'd10;
  localparam logic [3:0] PH_DLO      = 4'd11;
  localparam logic [3:0] PH_DHI      = 4'd12;
  localparam logic [3:0] PH_COPY     = 4'd13;
  localparam logic [3:0] PH_DONE     = 4'd14;

  localparam int DEF_WINDOW_DEPTH = 65536;
  localparam int DEF_LENGTH_WIDTH = 32;
  localparam int TOTAL_W          = 32;
  // Width of a computed match distance before the lookbehind check
  localparam int DIST_W           = 17;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
    logic       in_last;
  } lzo_in_t;

  typedef struct packed {
    logic               has_byte;
    logic [7:0]         out_byte;
    logic               has_status;
    logic [2:0]         status;
    logic [TOTAL_W-1:0] total_length;
    logic               need_input;
  } lzo_out_t;

endpackage

// ===== sv/lzo_if.sv =====
// Interfaces: valid/ready channels for compressed input items and decompressed results.
interface lzo_in_if import lzo_pkg::*; ();
  logic    valid;
  logic    ready;
  lzo_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lzo_out_if import lzo_pkg::*; ();
  logic     valid;
  logic     ready;
  lzo_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/lzo_hist_ram.sv =====
// History memory: one write port, one read port with registered read data.
module lzo_hist_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/lzo1x_stream_decompressor.sv =====
// Top level: LZO1X stream decompressor with history memory and result register.
// One item (a compressed byte feed or a match-copy advance) is taken every cycle while the
// result register is empty or being drained; each item's result is registered and shown in the next cycle. An
// advance reads one history byte through the single read port of the history memory; a byte
// emitted by the previous item that has not yet reached memory is forwarded from the result
// register, so distance-one copies also run at one byte per cycle. The history needs no
// clearing pass: reads are bounded by the fill level.
module lzo1x_stream_decompressor import lzo_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input logic        clk,
  input logic        rst_n,
  lzo_in_if.sink     in_chan,
  lzo_out_if.source  out_chan
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int LW = LENGTH_WIDTH;

  // Decoder state
  logic [3:0]         phase_r, phase_nxt;
  logic [LW-1:0]      pend_r, pend_nxt;
  logic [15:0]        dist_r, dist_nxt;
  logic [7:0]         dlo_r, dlo_nxt;
  logic [1:0]         trail_r, trail_nxt;
  logic               fin_r, fin_nxt;
  logic               far_r, far_nxt;
  logic               endp_r, endp_nxt;
  logic [2:0]         ends_r, ends_nxt;
  logic [2:0]         fstat_r, fstat_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [TOTAL_W-1:0] cnt_r, cnt_nxt;

  // Result register
  logic               s2_v_r;
  logic               s2_has_r;
  logic               s2_ram_r;
  logic [7:0]         s2_fwd_r;
  logic               s2_hs_r;
  logic [2:0]         s2_st_r;
  logic [TOTAL_W-1:0] s2_tl_r;
  logic               s2_ni_r;
  logic [AW-1:0]      s2_wp_r;

  logic          accept;
  logic          emit;
  logic          rd_en;
  logic          fwd_hit;
  logic [AW:0]   rd_sum;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_rdata;
  logic [7:0]    s2_byte;
  logic          ram_we;

  // Start-of-copy request from the parser
  logic              sc_go;
  logic [DIST_W-1:0] sc_d;
  logic [LW-1:0]     sc_len;
  logic              dec_go;
  logic [LW:0]       len_sum;
  logic [13:0]       dhi_v;
  logic [DIST_W-1:0] far_v;

  logic       cmd;
  logic [7:0] b;
  logic       last;
  logic [7:0] first_t;

  assign cmd  = in_chan.data.command;
  assign b    = in_chan.data.in_byte;
  assign last = in_chan.data.in_last;

  assign in_chan.ready = !s2_v_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // History read index for an advance
  always_comb begin
    rd_sum = {1'b0, wp_r} + (AW+1)'(WINDOW_DEPTH) - (AW+1)'(dist_r);
    if (rd_sum >= (AW+1)'(WINDOW_DEPTH)) begin
      rd_sum = rd_sum - (AW+1)'(WINDOW_DEPTH);
    end
    rd_addr = rd_sum[AW-1:0];
  end

  // Parser and copy control
  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    dist_nxt  = dist_r;
    dlo_nxt   = dlo_r;
    trail_nxt = trail_r;
    fin_nxt   = fin_r;
    far_nxt   = far_r;
    endp_nxt  = endp_r;
    ends_nxt  = ends_r;
    fstat_nxt = fstat_r;
    emit      = 1'b0;
    rd_en     = 1'b0;
    sc_go     = 1'b0;
    sc_d      = '0;
    sc_len    = '0;
    dec_go    = 1'b0;
    len_sum   = '0;
    dhi_v     = '0;
    far_v     = '0;
    first_t   = b - 8'd17;

    if (!fin_r) begin
      if (cmd == CMD_ADVANCE) begin
        if (phase_r == PH_COPY) begin
          emit     = 1'b1;
          rd_en    = 1'b1;
          pend_nxt = pend_r - LW'(1);
          if (pend_r == LW'(1)) begin
            phase_nxt = (trail_r != 2'd0) ? PH_TRAIL : PH_INSTR_A;
            if (endp_r) begin
              phase_nxt = PH_DONE;
              fin_nxt   = 1'b1;
              fstat_nxt = ends_r;
            end
          end
        end else begin
          phase_nxt = PH_DONE;
          fin_nxt   = 1'b1;
          fstat_nxt = ST_TURN;
        end
      end else if (phase_r == PH_COPY) begin
        phase_nxt = PH_DONE;
        fin_nxt   = 1'b1;
        fstat_nxt = ST_TURN;
      end else begin
        case (phase_r)
          PH_FIRST: begin
            if (b > 8'd17) begin
              if (first_t < 8'd4) begin
                trail_nxt = first_t[1:0];
                phase_nxt = PH_TRAIL;
              end else begin
                pend_nxt  = LW'(first_t);
                phase_nxt = PH_LITS;
              end
            end else begin
              dec_go = 1'b1;
            end
          end
          PH_INSTR_A, PH_INSTR_B, PH_INSTR_C: dec_go = 1'b1;
          PH_LITEXT, PH_MEXT: begin
            if (b == 8'd0) begin
              len_sum = {1'b0, pend_r} + (LW+1)'(255);
            end else if (phase_r == PH_LITEXT) begin
              len_sum = {1'b0, pend_r} + (LW+1)'(18) + (LW+1)'(b);
            end else begin
              len_sum = {1'b0, pend_r} + (LW+1)'(far_r ? 9 : 33) + (LW+1)'(b);
            end
            if (len_sum[LW]) begin
              phase_nxt = PH_DONE;
              fin_nxt   = 1'b1;
              fstat_nxt = ST_OVERFLOW;
            end else begin
              pend_nxt = len_sum[LW-1:0];
              if (b != 8'd0) begin
                phase_nxt = (phase_r == PH_LITEXT) ? PH_LITS : PH_DLO;
              end
            end
          end
          PH_LITS: begin
            emit     = 1'b1;
            pend_nxt = pend_r - LW'(1);
            if (pend_r == LW'(1)) begin
              phase_nxt = PH_INSTR_B;
            end
          end
          PH_TRAIL: begin
            emit      = 1'b1;
            trail_nxt = trail_r - 2'd1;
            if (trail_r == 2'd1) begin
              phase_nxt = PH_INSTR_C;
            end
          end
          PH_M1_SHORT, PH_M1_LONG: begin
            sc_go  = 1'b1;
            sc_d   = DIST_W'(dist_r) + DIST_W'({b, 2'b00});
            sc_len = (phase_r == PH_M1_LONG) ? LW'(3) : LW'(2);
          end
          PH_M2B: begin
            sc_go  = 1'b1;
            sc_d   = DIST_W'(dist_r) + DIST_W'({b, 3'b000});
            sc_len = pend_r;
          end
          PH_DLO: begin
            dlo_nxt   = b;
            trail_nxt = b[1:0];
            phase_nxt = PH_DHI;
          end
          PH_DHI: begin
            dhi_v = {b, dlo_r[7:2]};
            if (far_r) begin
              far_v = DIST_W'(dhi_v) + DIST_W'(dist_r);
              if (far_v == '0) begin
                phase_nxt = PH_DONE;
                fin_nxt   = 1'b1;
                fstat_nxt = last ? ST_OK : ST_AFTER_END;
              end else begin
                sc_go  = 1'b1;
                sc_d   = far_v + DIST_W'(16'h4000);
                sc_len = pend_r;
              end
            end else begin
              sc_go  = 1'b1;
              sc_d   = DIST_W'(dhi_v) + DIST_W'(1);
              sc_len = pend_r;
            end
          end
          default: begin
            phase_nxt = PH_DONE;
            fin_nxt   = 1'b1;
            fstat_nxt = ST_TURN;
          end
        endcase

        // Instruction decode
        if (dec_go) begin
          if (b >= 8'd64) begin
            pend_nxt  = LW'(b[7:5]) + LW'(1);
            dist_nxt  = 16'(b[4:2]) + 16'd1;
            trail_nxt = b[1:0];
            phase_nxt = PH_M2B;
          end else if (b >= 8'd16) begin
            far_nxt  = !b[5];
            dist_nxt = b[5] ? 16'd0 : {1'b0, b[3], 14'd0};
            if ((b[5] ? b[4:0] : {2'b00, b[2:0]}) == 5'd0) begin
              pend_nxt  = '0;
              phase_nxt = PH_MEXT;
            end else begin
              pend_nxt  = LW'(b[5] ? b[4:0] : {2'b00, b[2:0]}) + LW'(2);
              phase_nxt = PH_DLO;
            end
          end else if (phase_r == PH_FIRST || phase_r == PH_INSTR_A) begin
            if (b == 8'd0) begin
              pend_nxt  = '0;
              phase_nxt = PH_LITEXT;
            end else begin
              pend_nxt  = LW'(b) + LW'(3);
              phase_nxt = PH_LITS;
            end
          end else begin
            trail_nxt = b[1:0];
            if (phase_r == PH_INSTR_B) begin
              dist_nxt  = 16'(b[7:2]) + 16'h0801;
              phase_nxt = PH_M1_LONG;
            end else begin
              dist_nxt  = 16'(b[7:2]) + 16'd1;
              phase_nxt = PH_M1_SHORT;
            end
          end
        end

        // Match start with lookbehind check
        if (sc_go) begin
          if (sc_d == '0 || {1'b0, sc_d} > (DIST_W+1)'(fill_r)) begin
            phase_nxt = PH_DONE;
            fin_nxt   = 1'b1;
            fstat_nxt = ST_LOOKBEHIND;
          end else begin
            dist_nxt  = sc_d[15:0];
            pend_nxt  = sc_len;
            phase_nxt = PH_COPY;
            endp_nxt  = last;
            ends_nxt  = (trail_r != 2'd0) ? ST_OVERRUN : ST_NO_END;
          end
        end

        // Stream cut short while bytes are still owed
        if (last && phase_nxt != PH_DONE && phase_nxt != PH_COPY) begin
          phase_nxt = PH_DONE;
          fin_nxt   = 1'b1;
          fstat_nxt = ST_OVERRUN;
        end
      end
    end
  end

  // Write pointer, fill level and byte count
  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    if (emit) begin
      wp_nxt  = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      cnt_nxt = cnt_r + TOTAL_W'(1);
      if (fill_r < FW'(WINDOW_DEPTH)) begin
        fill_nxt = fill_r + FW'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      pend_r  <= '0;
      dist_r  <= '0;
      dlo_r   <= '0;
      trail_r <= '0;
      fin_r   <= 1'b0;
      far_r   <= 1'b0;
      endp_r  <= 1'b0;
      ends_r  <= ST_OK;
      fstat_r <= ST_OK;
      wp_r    <= '0;
      fill_r  <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      dist_r  <= dist_nxt;
      dlo_r   <= dlo_nxt;
      trail_r <= trail_nxt;
      fin_r   <= fin_nxt;
      far_r   <= far_nxt;
      endp_r  <= endp_nxt;
      ends_r  <= ends_nxt;
      fstat_r <= fstat_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Byte held in the result register; forwarded when the next read hits its slot
  assign s2_byte = s2_ram_r ? ram_rdata : s2_fwd_r;
  assign fwd_hit = s2_v_r && s2_has_r && (s2_wp_r == rd_addr);
  assign ram_we  = s2_v_r && out_chan.ready && s2_has_r;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (accept) begin
      s2_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_has_r <= emit;
      s2_ram_r <= rd_en && !fwd_hit;
      s2_fwd_r <= (rd_en && fwd_hit) ? s2_byte : b;
      s2_hs_r  <= fin_nxt;
      s2_st_r  <= fin_nxt ? fstat_nxt : ST_OK;
      s2_tl_r  <= cnt_nxt;
      s2_ni_r  <= !fin_nxt && (phase_nxt != PH_COPY);
      s2_wp_r  <= wp_r;
    end
  end

  lzo_hist_ram #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_wp_r),
    .wdata (s2_byte),
    .re    (accept && rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign out_chan.valid             = s2_v_r;
  assign out_chan.data.has_byte     = s2_has_r;
  assign out_chan.data.out_byte     = s2_has_r ? s2_byte : 8'd0;
  assign out_chan.data.has_status   = s2_hs_r;
  assign out_chan.data.status       = s2_st_r;
  assign out_chan.data.total_length = s2_tl_r;
  assign out_chan.data.need_input   = s2_ni_r;

`ifndef SYNTHESIS
  // Once finished, no further item emits a byte
  a_no_byte_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fin_r) |=> !s2_has_r)
    else $error("byte emitted after end of stream");

  // Fill level never exceeds the window
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW_DEPTH))
    else $error("fill level beyond window");

  // A pending copy always has bytes left
  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COPY) |-> (pend_r != '0))
    else $error("copy pending with zero length");
`endif

endmodule
